### src/rc5_ir_frame_pulse_encoder_unit_defines.svh
// Assertion macros used by the RC5 pulse encoder unit.
`ifndef RC5_IR_FRAME_PULSE_ENCODER_UNIT_DEFINES_SVH
`define RC5_IR_FRAME_PULSE_ENCODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define RC5_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rc5 encoder check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RC5_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rc5 encoder check failed");
`else
`define RC5_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define RC5_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif

`endif

### src/rc5enc_pkg.sv
// Shared constants and types of the RC5 infrared frame pulse encoder.
package rc5enc_pkg;

    localparam int unsigned KHZ_W     = 10;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned DIV_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned WORD_W    = 14;
    localparam int unsigned ENTRY_W   = 5;
    localparam int unsigned STEP_W    = 4;

    localparam logic [ENTRY_W-1:0] LAST_ENTRY = 5'd27;
    localparam logic [STEP_W-1:0]  LAST_STEP  = 4'd15;
    localparam logic [DIV_W-1:0]   US_PER_MS  = 16'd1000;
    localparam logic [KHZ_W-1:0]   KHZ_MIN    = 10'd1;
    localparam logic [KHZ_W-1:0]   KHZ_MAX    = 10'd1000;
    localparam logic [1:0]         START_BITS = 2'b11;

    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_KHZ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HALF_US  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HALF_US = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_sts_t;

endpackage

### src/rc5enc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rc5enc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rc5enc_pkg::div_ctl_t ctl,
    output rc5enc_pkg::div_sts_t sts
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [rc5enc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [rc5enc_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [rc5enc_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [rc5enc_pkg::DIV_W-1:0] dsr_reg, dsr_next;
    logic [rc5enc_pkg::DIV_W:0]   trial;
    logic [rc5enc_pkg::DIV_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[rc5enc_pkg::DIV_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = ctl.dividend;
            dsr_next  = ctl.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor, so it fits.
            if (!diff[rc5enc_pkg::DIV_W])
            begin
                rem_next = diff[rc5enc_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rc5enc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rc5enc_pkg::DIV_W-1:0];
                quo_next = {quo_reg[rc5enc_pkg::DIV_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == rc5enc_pkg::LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = quo_reg;

endmodule

### src/rc5_ir_frame_pulse_encoder_unit.sv
// RC5 frame pulse encoder: one request in, 28 level/duration entries out.
// An accepted request makes three passes through the shared divider (16 quotient steps and
// a hand-off each), then one load gives its first entry.
// One entry per cycle while the output is taken; the next request waits for the frame's end.
// Reset (rst_n, asynchronous, active low) clears the toggle bit and loads the registers
// with 36 kHz, 889 us and 861 us; no clearing pass is needed.
`include "rc5_ir_frame_pulse_encoder_unit_defines.svh"

module rc5_ir_frame_pulse_encoder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [rc5enc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc5enc_pkg::HALF_W-1:0]      cfg_data,
    // Request stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // [4:0] address, [10:5] command
    input  logic                               s_axis_tuser,  // [0] repeat_req
    // Pulse entry stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // [0] level, [16:1] duration_count
    output logic                               m_axis_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_D1,
        ST_D2,
        ST_EMIT
    } state_t;

    // Configuration registers.
    logic [rc5enc_pkg::KHZ_W-1:0]  carrier_khz_reg;
    logic [rc5enc_pkg::HALF_W-1:0] first_half_us_reg;
    logic [rc5enc_pkg::HALF_W-1:0] second_half_us_reg;

    state_t                         state_reg, state_next;
    logic                           toggle_reg, toggle_next;
    logic [rc5enc_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [rc5enc_pkg::ENTRY_W-1:0] entry_reg, entry_next;
    logic [rc5enc_pkg::DIV_W-1:0]   d1_reg, d1_next;
    logic [rc5enc_pkg::DIV_W-1:0]   d2_reg, d2_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_level_reg, out_level_next;
    logic [rc5enc_pkg::DIV_W-1:0]   out_dur_reg, out_dur_next;
    logic                           out_last_reg, out_last_next;

    logic                           in_xact;
    logic                           load_entry;
    logic                           cur_bit;
    logic [rc5enc_pkg::KHZ_W-1:0]   khz_clamped;
    logic [4:0]                     in_address;
    logic [5:0]                     in_command;
    rc5enc_pkg::div_ctl_t           div_ctl;
    rc5enc_pkg::div_sts_t           div_sts;

    assign in_address = s_axis_tdata[4:0];
    assign in_command = s_axis_tdata[10:5];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    // The carrier is held to 1..1000 kHz, so the base period is never zero.
    always_comb
    begin
        if (carrier_khz_reg < rc5enc_pkg::KHZ_MIN)
        begin
            khz_clamped = rc5enc_pkg::KHZ_MIN;
        end
        else if (carrier_khz_reg > rc5enc_pkg::KHZ_MAX)
        begin
            khz_clamped = rc5enc_pkg::KHZ_MAX;
        end
        else
        begin
            khz_clamped = carrier_khz_reg;
        end
    end

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_khz_reg    <= 10'd36;
            first_half_us_reg  <= 16'd889;
            second_half_us_reg <= 16'd861;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rc5enc_pkg::CFG_CARRIER_KHZ:
                    carrier_khz_reg <= cfg_data[rc5enc_pkg::KHZ_W-1:0];
                rc5enc_pkg::CFG_FIRST_HALF_US:
                    first_half_us_reg <= cfg_data;
                rc5enc_pkg::CFG_SECOND_HALF_US:
                    second_half_us_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // The divider is started three times in a row. The base period of the first pass
    // goes straight from the divider output into the second pass, and from d1_reg into the third.
    always_comb
    begin
        div_ctl.start    = 1'b0;
        div_ctl.dividend = rc5enc_pkg::US_PER_MS;
        div_ctl.divisor  = {{(rc5enc_pkg::DIV_W - rc5enc_pkg::KHZ_W){1'b0}}, khz_clamped};
        unique case (state_reg)
            ST_IDLE:
                div_ctl.start = in_xact;
            ST_BASE:
            begin
                div_ctl.start    = div_sts.done;
                div_ctl.dividend = first_half_us_reg;
                div_ctl.divisor  = div_sts.quotient;
            end
            ST_D1:
            begin
                div_ctl.start    = div_sts.done;
                div_ctl.dividend = second_half_us_reg;
                div_ctl.divisor  = d1_reg;
            end
            default:
                ;
        endcase
    end

    rc5enc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    // During ST_D1 the base period is parked in d1_reg, then replaced by the
    // first-half count when the second pass ends.
    assign load_entry = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign cur_bit    = word_reg[rc5enc_pkg::WORD_W-1];

    always_comb
    begin
        state_next     = state_reg;
        toggle_next    = toggle_reg;
        word_next      = word_reg;
        entry_next     = entry_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        out_level_next = out_level_reg;
        out_dur_next   = out_dur_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    // A fresh key press flips the toggle bit before it is sent.
                    toggle_next = s_axis_tuser ? toggle_reg : !toggle_reg;
                    word_next   = {rc5enc_pkg::START_BITS, toggle_next, in_address, in_command};
                    entry_next  = '0;
                    state_next  = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (div_sts.done)
                begin
                    d1_next    = div_sts.quotient;
                    state_next = ST_D1;
                end
            end
            ST_D1:
            begin
                if (div_sts.done)
                begin
                    d1_next    = div_sts.quotient;
                    state_next = ST_D2;
                end
            end
            ST_D2:
            begin
                if (div_sts.done)
                begin
                    d2_next    = div_sts.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_entry)
                begin
                    // A one is sent low then high, a zero high then low.
                    out_valid_next = 1'b1;
                    out_level_next = entry_reg[0] ? cur_bit : !cur_bit;
                    out_dur_next   = entry_reg[0] ? d2_reg : d1_reg;
                    out_last_next  = (entry_reg == rc5enc_pkg::LAST_ENTRY);
                    if (entry_reg[0])
                    begin
                        word_next = {word_reg[rc5enc_pkg::WORD_W-2:0], 1'b0};
                    end
                    if (entry_reg == rc5enc_pkg::LAST_ENTRY)
                    begin
                        entry_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        entry_next = entry_reg + 1'b1;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            toggle_reg    <= 1'b0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
            word_reg      <= '0;
            d1_reg        <= '0;
            d2_reg        <= '0;
            out_level_reg <= 1'b0;
            out_dur_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            toggle_reg    <= toggle_next;
            entry_reg     <= entry_next;
            out_valid_reg <= out_valid_next;
            word_reg      <= word_next;
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            out_level_reg <= out_level_next;
            out_dur_reg   <= out_dur_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_dur_reg, out_level_reg};
    assign m_axis_tlast  = out_last_reg;

    // A division only ends while the sequencer is waiting for it.
    `RC5_ASSERT_IMP(a_div_done_expected, clk, rst_n, div_sts.done,
        (state_reg == ST_BASE) || (state_reg == ST_D1) || (state_reg == ST_D2))
    // A fresh request always flips the toggle bit.
    `RC5_ASSERT_NXT(a_toggle_flips, clk, rst_n, in_xact && !s_axis_tuser,
        toggle_reg != $past(toggle_reg))
    // The entry counter never runs past the end of the frame.
    `RC5_ASSERT_IMP(a_entry_bound, clk, rst_n, state_reg == ST_EMIT,
        entry_reg <= rc5enc_pkg::LAST_ENTRY)

endmodule
